// ===== hw/rtl/rvalu_pkg.sv =====
// Shared types, constants and helpers for the RV32I integer ALU with register file.
package rvalu_pkg;

    // Datapath and register file geometry.
    localparam int XLEN      = 32;
    localparam int REG_IDX_W = 5;
    localparam int REG_COUNT = 32;
    localparam int RF_AW     = $clog2(REG_COUNT);
    localparam int SHAMT_W   = 5;
    localparam int INSTR_W   = 32;

    // Opcode and funct7 codes of the standard encoding.
    localparam logic [6:0] OPC_REG = 7'b0110011;
    localparam logic [6:0] OPC_IMM = 7'b0010011;
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // Operation selected by funct3.
    typedef enum logic [2:0] {
        F3_ADD  = 3'd0,
        F3_SLL  = 3'd1,
        F3_SLT  = 3'd2,
        F3_SLTU = 3'd3,
        F3_XOR  = 3'd4,
        F3_SR   = 3'd5,
        F3_OR   = 3'd6,
        F3_AND  = 3'd7
    } t_funct3;

    // Register file write port.
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [XLEN-1:0]      data;
    } t_rf_wr;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [REG_IDX_W-1:0] dest_index;
        logic [XLEN-1:0]      write_value;
        logic                 write_done;
        logic                 unsupported;
    } t_result;

    // True when a register number names an existing register.
    function automatic logic reg_in_range(input logic [REG_IDX_W-1:0] idx);
        return (int'(idx) < REG_COUNT);
    endfunction

endpackage

// ===== hw/rtl/rvalu_ifs.sv =====
// Valid/ready channel interfaces for instruction words and result words.
interface rvalu_in_if
    import rvalu_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INSTR_W-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface rvalu_out_if
    import rvalu_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] dest_index;
    logic [XLEN-1:0]      write_value;
    logic                 write_done;
    logic                 unsupported;

    modport source (output valid, output dest_index, output write_value,
                    output write_done, output unsupported, input ready);
    modport sink   (input valid, input dest_index, input write_value,
                    input write_done, input unsupported, output ready);
endinterface

// ===== hw/rtl/rvalu_regfile.sv =====
// Register file: two registered read ports, one write port, per-entry valid bits for reset.
module rvalu_regfile
    import rvalu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [REG_IDX_W-1:0] i_rs1,
    input  logic [REG_IDX_W-1:0] i_rs2,
    input  t_rf_wr               i_wr,
    output logic [XLEN-1:0]      o_rs1_data,
    output logic [XLEN-1:0]      o_rs2_data
);

    logic [XLEN-1:0]      r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [XLEN-1:0]      r_rd1;
    logic [XLEN-1:0]      r_rd2;
    logic                 r_ok1;
    logic                 r_ok2;
    logic [RF_AW-1:0]     rs1_addr;
    logic [RF_AW-1:0]     rs2_addr;
    logic [RF_AW-1:0]     wr_addr;

    assign rs1_addr = i_rs1[RF_AW-1:0];
    assign rs2_addr = i_rs2[RF_AW-1:0];
    assign wr_addr  = i_wr.addr[RF_AW-1:0];

    // Storage array and registered read data.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd1 <= r_mem[rs1_addr];
            r_rd2 <= r_mem[rs2_addr];
        end
    end

    // Valid bits stand in for clearing the array at reset; x0 and missing registers read zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ok1 <= 1'b0;
            r_ok2 <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_ok1 <= (i_rs1 != '0) && reg_in_range(i_rs1) && r_vld[rs1_addr];
                r_ok2 <= (i_rs2 != '0) && reg_in_range(i_rs2) && r_vld[rs2_addr];
            end
        end
    end

    assign o_rs1_data = r_ok1 ? r_rd1 : '0;
    assign o_rs2_data = r_ok2 ? r_rd2 : '0;

endmodule

// ===== hw/rtl/rvalu_exec.sv =====
// Instruction decode and ALU: turns one word and its operands into a result word.
module rvalu_exec
    import rvalu_pkg::*;
(
    input  logic [INSTR_W-1:0] i_instr,
    input  logic [XLEN-1:0]    i_rs1_val,
    input  logic [XLEN-1:0]    i_rs2_val,
    output t_result            o_result
);

    logic [6:0]           opcode;
    logic [6:0]           funct7;
    logic [REG_IDX_W-1:0] rd;
    t_funct3              funct3;
    logic [XLEN-1:0]      imm;
    logic [XLEN-1:0]      op_b;
    logic [SHAMT_W-1:0]   shamt;
    logic                 alt;
    logic                 ok;
    logic                 f7_legal;
    logic                 we;
    logic [XLEN-1:0]      alu_out;

    // Field extraction.
    assign opcode   = i_instr[6:0];
    assign rd       = i_instr[11:7];
    assign funct3   = t_funct3'(i_instr[14:12]);
    assign funct7   = i_instr[31:25];
    assign imm      = {{(XLEN-12){i_instr[31]}}, i_instr[31:20]};
    assign f7_legal = (funct7 == F7_BASE) || (funct7 == F7_ALT);

    // Legality and operand selection.
    always_comb begin
        ok   = 1'b0;
        alt  = 1'b0;
        op_b = '0;
        if (opcode == OPC_REG) begin
            op_b = i_rs2_val;
            alt  = (funct7 == F7_ALT);
            ok   = f7_legal && (!alt || funct3 == F3_ADD || funct3 == F3_SR);
        end else if (opcode == OPC_IMM) begin
            op_b = imm;
            case (funct3)
                F3_SLL: begin
                    ok = (funct7 == F7_BASE);
                end
                F3_SR: begin
                    ok  = f7_legal;
                    alt = (funct7 == F7_ALT);
                end
                default: begin
                    ok = 1'b1;
                end
            endcase
        end
    end

    assign shamt = op_b[SHAMT_W-1:0];

    // Arithmetic and logic operations.
    always_comb begin
        case (funct3)
            F3_ADD:  alu_out = alt ? (i_rs1_val - op_b) : (i_rs1_val + op_b);
            F3_SLL:  alu_out = i_rs1_val << shamt;
            F3_SLT:  alu_out = {{(XLEN-1){1'b0}}, ($signed(i_rs1_val) < $signed(op_b))};
            F3_SLTU: alu_out = {{(XLEN-1){1'b0}}, (i_rs1_val < op_b)};
            F3_XOR:  alu_out = i_rs1_val ^ op_b;
            F3_SR:   alu_out = alt ? XLEN'($signed(i_rs1_val) >>> shamt) : (i_rs1_val >> shamt);
            F3_OR:   alu_out = i_rs1_val | op_b;
            F3_AND:  alu_out = i_rs1_val & op_b;
            default: alu_out = '0;
        endcase
    end

    // Result word: x0 and missing registers take no write.
    assign we                   = ok && (rd != '0) && reg_in_range(rd);
    assign o_result.dest_index  = ok ? rd : '0;
    assign o_result.write_value = we ? alu_out : '0;
    assign o_result.write_done  = we;
    assign o_result.unsupported = !ok;

endmodule

// ===== hw/rtl/rv32i_integer_alu_regfile_top.sv =====
// Top level of the RV32I integer ALU with register file.
// Accepts one RV32I instruction word per cycle while the output channel is not
// stalled, and returns one result word per instruction, in order. The register
// file read is registered as the word is accepted, decode, ALU and write-back
// happen in the execute stage, and the result is held in an output register.
// The ALU is combinational and the register file has one write port; the last
// write is forwarded so back-to-back dependent instructions see fresh values.
// Register and immediate ALU operations are executed; every other word returns
// unsupported with no register write.
// The register file reads as zero after reset without any clearing pass.
module rv32i_integer_alu_regfile_top
    import rvalu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    rvalu_in_if.sink        i_in,
    rvalu_out_if.source     o_out
);

    logic                 in_accept;
    logic                 s1_adv;
    logic                 r_s1_valid;
    logic [INSTR_W-1:0]   r_s1_instr;
    logic                 r_out_valid;
    t_result              r_out;
    logic                 r_fwd_valid;
    logic [REG_IDX_W-1:0] r_fwd_idx;
    logic [XLEN-1:0]      r_fwd_data;
    logic [XLEN-1:0]      rf_rs1;
    logic [XLEN-1:0]      rf_rs2;
    logic [XLEN-1:0]      rs1_val;
    logic [XLEN-1:0]      rs2_val;
    logic [REG_IDX_W-1:0] s1_rs1;
    logic [REG_IDX_W-1:0] s1_rs2;
    t_rf_wr               rf_wr;
    t_result              exec_res;

    // Handshake: the execute stage moves whenever the output register is free or drained.
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in.valid && i_in.ready;

    // Register file, read as the word is accepted.
    rvalu_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rs1      (i_in.instruction[19:15]),
        .i_rs2      (i_in.instruction[24:20]),
        .i_wr       (rf_wr),
        .o_rs1_data (rf_rs1),
        .o_rs2_data (rf_rs2)
    );

    // Forward the latest write, which may land in the same cycle as the read.
    assign s1_rs1  = r_s1_instr[19:15];
    assign s1_rs2  = r_s1_instr[24:20];
    assign rs1_val = (r_fwd_valid && r_fwd_idx == s1_rs1) ? r_fwd_data : rf_rs1;
    assign rs2_val = (r_fwd_valid && r_fwd_idx == s1_rs2) ? r_fwd_data : rf_rs2;

    rvalu_exec u_exec (
        .i_instr   (r_s1_instr),
        .i_rs1_val (rs1_val),
        .i_rs2_val (rs2_val),
        .o_result  (exec_res)
    );

    // Write-back as the word leaves the execute stage.
    assign rf_wr.en   = s1_adv && exec_res.write_done;
    assign rf_wr.addr = exec_res.dest_index;
    assign rf_wr.data = exec_res.write_value;

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_instr <= i_in.instruction;
        end
        if (s1_adv) begin
            r_out <= exec_res;
        end
        if (rf_wr.en) begin
            r_fwd_idx  <= rf_wr.addr;
            r_fwd_data <= rf_wr.data;
        end
    end

    // Stage valid bits and forwarding valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (rf_wr.en) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    // Output channel.
    assign o_out.valid       = r_out_valid;
    assign o_out.dest_index  = r_out.dest_index;
    assign o_out.write_value = r_out.write_value;
    assign o_out.write_done  = r_out.write_done;
    assign o_out.unsupported = r_out.unsupported;

endmodule
